>>> src/gf16_pkg.sv
// shared types, constants and GF(2^16) arithmetic functions
package gf16_pkg;

    // field size and reduction polynomial x^16 + x^5 + x^3 + x^2 + 1
    localparam int unsigned ELEM_W  = 16;
    localparam int unsigned EXP_W   = 32;
    localparam int unsigned NUM_STAGES = EXP_W;
    localparam logic [ELEM_W:0] GF_POLY = 17'h1002d;

    // operation codes
    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_POW = 1'b1;

    // payload carried down the square-and-multiply pipeline
    typedef struct packed {
        logic               zero;   // power of a zero base, forces result 0
        logic [ELEM_W-1:0]  acc;    // running product
        logic [ELEM_W-1:0]  sq;     // running square of the base
        logic [EXP_W-1:0]   exp;    // exponent bits not yet consumed, lsb next
    } gf16_lane_t;

    // reduce a 31-bit carryless product modulo the field polynomial
    function automatic logic [ELEM_W-1:0] gf_reduce(input logic [2*ELEM_W-2:0] p);
        logic [ELEM_W+3:0] t;
        logic [ELEM_W-1:0] u;
        logic [ELEM_W-2:0] h;
        logic [3:0]        g;
        h = p[2*ELEM_W-2:ELEM_W];
        t = {4'b0, p[ELEM_W-1:0]};
        // first fold: high bits times the low part of the polynomial
        for (int j = 0; j < 6; j++)
        begin
            if (GF_POLY[j])
                t = t ^ ({5'b0, h} << j);
        end
        g = t[ELEM_W+3:ELEM_W];
        u = t[ELEM_W-1:0];
        // second fold: at most four bits remain above the field width
        for (int j = 0; j < 6; j++)
        begin
            if (GF_POLY[j])
                u = u ^ ({12'b0, g} << j);
        end
        return u;
    endfunction

    // field product
    function automatic logic [ELEM_W-1:0] gf_mul(input logic [ELEM_W-1:0] a,
                                                 input logic [ELEM_W-1:0] b);
        logic [2*ELEM_W-2:0] p;
        p = '0;
        for (int i = 0; i < ELEM_W; i++)
        begin
            if (b[i])
                p = p ^ ({15'b0, a} << i);
        end
        return gf_reduce(p);
    endfunction

    // field square: spread bits, then reduce
    function automatic logic [ELEM_W-1:0] gf_sqr(input logic [ELEM_W-1:0] a);
        logic [2*ELEM_W-2:0] p;
        p = '0;
        for (int i = 0; i < ELEM_W; i++)
        begin
            p[2*i] = a[i];
        end
        return gf_reduce(p);
    endfunction

endpackage

>>> src/gf16_step.sv
// one registered square-and-multiply step of the power pipeline
module gf16_step
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  gf16_pkg::gf16_lane_t lane_in,
    output logic                 valid_out,
    output gf16_pkg::gf16_lane_t lane_out
);

    logic                 valid_reg;
    gf16_pkg::gf16_lane_t lane_reg;
    gf16_pkg::gf16_lane_t lane_next;
    logic [gf16_pkg::ELEM_W-1:0] prod;

    // multiply in the square when the current exponent bit is set
    always_comb
    begin
        prod = gf16_pkg::gf_mul(lane_in.acc, lane_in.sq);
        lane_next.zero = lane_in.zero;
        lane_next.acc  = lane_in.exp[0] ? prod : lane_in.acc;
        lane_next.sq   = gf16_pkg::gf_sqr(lane_in.sq);
        lane_next.exp  = {1'b0, lane_in.exp[gf16_pkg::EXP_W-1:1]};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;

endmodule

>>> src/gf65536_multiply_power.sv
// top level: GF(2^16) multiply and power unit, 32-stage pipeline
//
// Command channel: an item is taken at each rising edge where start is high
// and busy is low. busy is never raised, so a new item may enter every cycle.
// cmd selects multiply (operand_a * operand_b) or power
// (operand_a ^ exponent); the unused operand is ignored.
// Result channel: done is high for one cycle with result valid in that cycle;
// the receiver must take it then, there is no back-pressure.
// Path: 32 square-and-multiply stages, one per exponent bit, each holding one
// field multiplier, then an output register. Multiply uses the first stage's
// multiplier only and travels through the same stages.
// Throughput: one item per cycle, results come out in input order.
// Reset clears all valid bits and done; items in flight are dropped.
// A zero base gives 0 for power, exponent zero included.
module gf65536_multiply_power
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [31:0] exponent,
    output logic        done,
    output logic [15:0] result
);

    localparam int unsigned N = gf16_pkg::NUM_STAGES;

    logic                 valid_chain [N+1];
    gf16_pkg::gf16_lane_t lane_chain  [N+1];
    logic                 done_reg;
    logic [15:0]          result_reg;
    logic [15:0]          result_next;

    assign busy = 1'b0;

    // load the lane: multiply is acc = a times sq = b at the first stage only
    always_comb
    begin
        valid_chain[0] = start & ~busy;
        if (cmd == gf16_pkg::CMD_POW)
        begin
            lane_chain[0].zero = (operand_a == 16'd0);
            lane_chain[0].acc  = 16'd1;
            lane_chain[0].sq   = operand_a;
            lane_chain[0].exp  = exponent;
        end
        else
        begin
            lane_chain[0].zero = 1'b0;
            lane_chain[0].acc  = operand_a;
            lane_chain[0].sq   = operand_b;
            lane_chain[0].exp  = 32'd1;
        end
    end

    // square-and-multiply stages, one exponent bit each
    for (genvar s = 0; s < N; s++)
    begin : g_step
        gf16_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[s]),
            .lane_in   (lane_chain[s]),
            .valid_out (valid_chain[s+1]),
            .lane_out  (lane_chain[s+1])
        );
    end

    // output register, zero base overrides the product
    assign result_next = lane_chain[N].zero ? 16'd0 : lane_chain[N].acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_chain[N];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a result only follows an item taken at the pipeline input
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 33))
        else $error("result strobe without a matching item");

    // zero base power gives zero
    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(start && cmd && (operand_a == 16'd0), 33) |-> result == 16'd0)
        else $error("power of zero base is not zero");

    // multiply by one returns the other operand
    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(start && !cmd && (operand_b == 16'd1), 33)
            |-> result == $past(operand_a, 33))
        else $error("multiply by one changed the operand");

    // power with exponent one of a nonzero base returns the base
    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(start && cmd && (exponent == 32'd1), 33)
            |-> result == $past(operand_a, 33))
        else $error("power with exponent one changed the base");

endmodule

>>> tb/sv/gf65536_result_checker.sv
// checker for the GF(2^16) multiply and power unit: predicts each result and compares
module gf65536_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        cmd,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [31:0] exponent,
    input  logic        done,
    input  logic [15:0] result,
    output int          fail_count,
    output int          awaiting_count,
    output int          compared_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // field elements still owed by the unit, oldest first
    logic [15:0] owed_elements[$];

    // shift-and-add product, folding x^16 back in as the low polynomial terms
    function automatic logic [15:0] field_product(input logic [15:0] x, input logic [15:0] y);
        logic [16:0] shifted;
        logic [15:0] sum;
        shifted = {1'b0, x};
        sum = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (y[k])
                sum = sum ^ shifted[15:0];
            shifted = shifted << 1;
            if (shifted[16])
                shifted = shifted ^ gf16_pkg::GF_POLY;
        end
        return sum;
    endfunction

    // square-and-multiply over all 32 exponent bits; a zero base always gives 0
    function automatic logic [15:0] field_power(input logic [15:0] base,
                                                input logic [31:0] power);
        logic [15:0] acc;
        logic [15:0] sq;
        acc = 16'h0001;
        sq = base;
        if (base == '0)
            return '0;
        for (int k = 0; k < 32; k++)
        begin
            if (power[k])
                acc = field_product(acc, sq);
            sq = field_product(sq, sq);
        end
        return acc;
    endfunction

    initial
    begin
        fail_count = 0;
        compared_count = 0;
        awaiting_count = 0;
    end

    // compare the result leaving the unit, then record the item entering it
    always @(posedge clk)
    begin
        logic [15:0] want;
        logic [15:0] fresh;
        if (rst_n)
        begin
            if (done)
            begin
                if (owed_elements.size() == 0)
                begin
                    $error("result 0x%04h with no item outstanding", result);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = owed_elements.pop_front();
                    compared_count = compared_count + 1;
                    if (result !== want)
                    begin
                        $error("result mismatch: expected 0x%04h, actual 0x%04h", want, result);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd == gf16_pkg::CMD_MUL)
                    fresh = field_product(operand_a, operand_b);
                else
                    fresh = field_power(operand_a, exponent);
                owed_elements = {owed_elements, fresh};
            end
        end
        awaiting_count = owed_elements.size();
    end

endmodule

>>> tb/sv/gf65536_multiply_power_test.sv
// testbench top: drives multiply and power items into the unit and gives the verdict
module gf65536_multiply_power_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1850;
    localparam int STEADY_TAIL  = 200;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [31:0] exponent;
    logic        done;
    logic [15:0] result;

    int fail_count;
    int awaiting_count;
    int compared_count;
    int mul_sent;
    int pow_sent;

    gf65536_multiply_power DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .exponent  (exponent),
        .done      (done),
        .result    (result)
    );

    gf65536_result_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .exponent       (exponent),
        .done           (done),
        .result         (result),
        .fail_count     (fail_count),
        .awaiting_count (awaiting_count),
        .compared_count (compared_count)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("timeout waiting for the unit");
        $display("CHECKS FAILED");
        $finish;
    end

    // present one item at the current falling edge and hold it until taken
    task automatic send_item(input logic op, input logic [15:0] a, input logic [15:0] b,
                             input logic [31:0] e);
        start = 1'b1;
        cmd = op;
        operand_a = a;
        operand_b = b;
        exponent = e;
        if (op == gf16_pkg::CMD_MUL)
            mul_sent = mul_sent + 1;
        else
            pow_sent = pow_sent + 1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random pause between items, with start low
    task automatic maybe_pause(input bit allowed);
        if (allowed && $urandom_range(0, 7) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    // element biased toward zero, one, all ones and single bits
    function automatic logic [15:0] pick_element();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hffff;
            3: return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // exponent biased toward zero, all ones, small values and single bits
    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'($urandom_range(1, 20));
            3: return 32'h1 << $urandom_range(0, 31);
            4: return 32'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic op;
        start = 1'b0;
        cmd = gf16_pkg::CMD_MUL;
        operand_a = '0;
        operand_b = '0;
        exponent = '0;
        mul_sent = 0;
        pow_sent = 0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero factors, reduction edges, zero base, zero exponent, group order
        send_item(gf16_pkg::CMD_MUL, 16'h0000, 16'h1234, $urandom);
        send_item(gf16_pkg::CMD_MUL, 16'habcd, 16'h0000, $urandom);
        send_item(gf16_pkg::CMD_MUL, 16'hffff, 16'hffff, 32'hffff_ffff);
        send_item(gf16_pkg::CMD_MUL, 16'h0001, 16'h5a5a, 32'h0);
        send_item(gf16_pkg::CMD_MUL, 16'h8000, 16'h8000, $urandom);
        send_item(gf16_pkg::CMD_MUL, 16'h8000, 16'h0002, $urandom);
        maybe_pause(1'b1);
        send_item(gf16_pkg::CMD_POW, 16'h0000, 16'($urandom), 32'h0000_0000);
        send_item(gf16_pkg::CMD_POW, 16'h0000, 16'($urandom), 32'hffff_ffff);
        send_item(gf16_pkg::CMD_POW, 16'h0000, 16'($urandom), 32'h0000_0001);
        send_item(gf16_pkg::CMD_POW, 16'h1234, 16'($urandom), 32'h0000_0000);
        send_item(gf16_pkg::CMD_POW, 16'hffff, 16'($urandom), 32'h0000_0000);
        send_item(gf16_pkg::CMD_POW, 16'h0002, 16'($urandom), 32'h0000_ffff);
        send_item(gf16_pkg::CMD_POW, 16'h0002, 16'($urandom), 32'h0000_0001);
        send_item(gf16_pkg::CMD_POW, 16'h0002, 16'($urandom), 32'h0000_0010);
        send_item(gf16_pkg::CMD_POW, 16'hffff, 16'hffff, 32'hffff_ffff);
        send_item(gf16_pkg::CMD_POW, 16'h8000, 16'($urandom), 32'h8000_0000);
        send_item(gf16_pkg::CMD_POW, 16'h0001, 16'($urandom), $urandom);
        send_item(gf16_pkg::CMD_POW, 16'h7e3c, 16'($urandom), 32'h0000_fffe);
        maybe_pause(1'b1);

        // random items, no pauses in the closing stretch
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            op = ($urandom_range(0, 4) < 2) ? gf16_pkg::CMD_MUL : gf16_pkg::CMD_POW;
            send_item(op, pick_element(), pick_element(), pick_exponent());
            maybe_pause(n < RANDOM_ITEMS - STEADY_TAIL);
        end
        start = 1'b0;

        // drain the pipeline
        while (awaiting_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d multiply and %0d power items, %0d results compared",
                 mul_sent, pow_sent, compared_count);
        $display("stimulus covered zero operands, zero exponents and bursty input");
        if (fail_count == 0 && awaiting_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
src/gf16_pkg.sv
src/gf16_step.sv
src/gf65536_multiply_power.sv
tb/sv/gf65536_result_checker.sv
tb/sv/gf65536_multiply_power_test.sv
